@@ hw/rtl/sfcg_pkg.sv @@
package sfcg_pkg;

  localparam int ADDR_W    = 22;
  localparam int CAP_W     = 12;
  localparam int TICK_W    = 16;
  localparam int SPACE_W   = 16;
  localparam int MAX_RES   = 5;
  localparam int CNT_W     = 3;

  localparam logic [ADDR_W-1:0] RST_FIFO_ADDR  = 22'h302578;
  localparam logic [ADDR_W-1:0] RST_SPACE_ADDR = 22'h302574;
  localparam logic [CAP_W-1:0]  RST_CAPACITY   = 12'd4092;
  localparam logic [TICK_W-1:0] RST_TIMEOUT    = 16'd250;

  typedef enum logic [2:0] {
    CMD_SELECT   = 3'd0,
    CMD_DATA     = 3'd1,
    CMD_DESELECT = 3'd2,
    CMD_SPACE    = 3'd3,
    CMD_TICK     = 3'd4,
    CMD_RECEIVE  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_READ    = 3'd2,
    ACT_ASSERT  = 3'd3,
    ACT_SEND    = 3'd4,
    ACT_RECEIVE = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CONTEXT     = 3'd1,
    ST_SPACE_FAULT = 3'd2,
    ST_TIMEOUT     = 3'd3,
    ST_BUS         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_FIFO_ADDR  = 2'd0,
    REG_SPACE_ADDR = 2'd1,
    REG_CAPACITY   = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] fifo_address;
    logic [ADDR_W-1:0] space_address;
    logic [CAP_W-1:0]  fifo_capacity;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    status_t                 status;
    res_t [MAX_RES-1:0]      res;
  } res_list_t;

endpackage

@@ hw/rtl/spi_fifo_credit_gate.sv @@
// Credit-gated serial-bus front end. The first result word of an accepted item
// goes straight to the output register if that is free, else to the result queue.
// An item produces 1 to 5 result words; one-word items go at one per cycle when
// the output is not stalled. The input stalls while words of the previous item
// still sit in the result queue. Reset (rst, synchronous, active high) clears
// all transaction state and loads the register defaults.
module spi_fifo_credit_gate (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [sfcg_pkg::ADDR_W-1:0]  cfg_data,
  // input word channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   cmd,
  input  logic [7:0]                   data_byte,
  input  logic [sfcg_pkg::SPACE_W-1:0] space_value,
  input  logic                         bus_ok,
  // result word channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   action,
  output logic [7:0]                   out_byte,
  output logic [sfcg_pkg::ADDR_W-1:0]  read_address,
  output logic [2:0]                   status,
  output logic                         last
);
  import sfcg_pkg::*;

  cfg_t      cfg;
  res_list_t lst;
  logic      accept;
  logic      busy;

  // Take a new word whenever the result queue is drained; the output register
  // may still hold the final word of the previous item.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // Register file: fifo address, space address, capacity, timeout.
  sfcg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Transaction state and decode: header capture, credit accounting, space
  // polling. Produces the full list of result words for the accepted item.
  sfcg_step u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .space_value (space_value),
    .bus_ok      (bus_ok),
    .cfg         (cfg),
    .lst         (lst)
  );

  // Result queue and output register: hand out one word per cycle while the output is not stalled.
  sfcg_out u_out (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .lst           (lst),
    .space_address (cfg.space_address),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .out_byte      (out_byte),
    .read_address  (read_address),
    .status        (status),
    .last          (last)
  );

endmodule

@@ hw/rtl/sfcg_cfg.sv @@
module sfcg_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [sfcg_pkg::ADDR_W-1:0] cfg_data,
  output sfcg_pkg::cfg_t              cfg
);
  import sfcg_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fifo_address  <= RST_FIFO_ADDR;
      cfg.space_address <= RST_SPACE_ADDR;
      cfg.fifo_capacity <= RST_CAPACITY;
      cfg.timeout_ticks <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIFO_ADDR:  cfg.fifo_address  <= cfg_data;
        REG_SPACE_ADDR: cfg.space_address <= cfg_data;
        REG_CAPACITY:   cfg.fifo_capacity <= cfg_data[CAP_W-1:0];
        REG_TIMEOUT:    cfg.timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sfcg_step.sv @@
module sfcg_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [2:0]                   cmd,
  input  logic [7:0]                   data_byte,
  input  logic [sfcg_pkg::SPACE_W-1:0] space_value,
  input  logic                         bus_ok,
  input  sfcg_pkg::cfg_t               cfg,
  output sfcg_pkg::res_list_t          lst
);
  import sfcg_pkg::*;

  logic              is_selected, is_selected_next;
  logic [1:0]        header_count, header_count_next;
  logic [23:0]       header_bytes, header_bytes_next;
  logic              fifo_mode, fifo_mode_next;
  logic              cs_asserted, cs_asserted_next;
  logic [CAP_W-1:0]  credit_left, credit_left_next;
  logic [1:0]        burst_phase, burst_phase_next;
  logic              awaiting_space, awaiting_space_next;
  logic [TICK_W-1:0] wait_count, wait_count_next;
  logic [7:0]        pending_byte, pending_byte_next;
  logic              pending_valid, pending_valid_next;

  logic [23:0]       hdr_new;
  logic [TICK_W-1:0] wait_inc;

  assign hdr_new  = {header_bytes[15:0], data_byte};
  assign wait_inc = (wait_count != {TICK_W{1'b1}}) ? wait_count + 1'b1 : wait_count;

  always_comb begin
    is_selected_next    = is_selected;
    header_count_next   = header_count;
    header_bytes_next   = header_bytes;
    fifo_mode_next      = fifo_mode;
    cs_asserted_next    = cs_asserted;
    credit_left_next    = credit_left;
    burst_phase_next    = burst_phase;
    awaiting_space_next = awaiting_space;
    wait_count_next     = wait_count;
    pending_byte_next   = pending_byte;
    pending_valid_next  = pending_valid;
    lst                 = '0;
    lst.status          = ST_OK;

    unique case (cmd)
      CMD_SELECT: begin
        if (is_selected) begin
          lst.status = ST_CONTEXT;
        end else begin
          is_selected_next    = 1'b1;
          header_count_next   = 2'd0;
          fifo_mode_next      = 1'b0;
          cs_asserted_next    = 1'b0;
          awaiting_space_next = 1'b0;
          pending_valid_next  = 1'b0;
          credit_left_next    = '0;
          burst_phase_next    = 2'd0;
          wait_count_next     = '0;
        end
      end
      CMD_DATA: begin
        if (!is_selected || awaiting_space) begin
          lst.status = ST_CONTEXT;
        end else if (header_count != 2'd3) begin
          header_bytes_next = hdr_new;
          header_count_next = header_count + 2'd1;
          if (header_count == 2'd2) begin
            if (hdr_new[23] && (hdr_new[ADDR_W-1:0] == cfg.fifo_address)) begin
              fifo_mode_next      = 1'b1;
              awaiting_space_next = 1'b1;
              wait_count_next     = '0;
              cs_asserted_next    = 1'b0;
              if (cs_asserted) begin
                lst.res[0] = '{ACT_RELEASE, 8'd0};
                lst.res[1] = '{ACT_READ, 8'd0};
                lst.cnt    = 3'd2;
              end else begin
                lst.res[0] = '{ACT_READ, 8'd0};
                lst.cnt    = 3'd1;
              end
            end else begin
              fifo_mode_next   = 1'b0;
              cs_asserted_next = 1'b1;
              lst.res[0] = '{ACT_ASSERT, 8'd0};
              lst.res[1] = '{ACT_SEND, hdr_new[23:16]};
              lst.res[2] = '{ACT_SEND, hdr_new[15:8]};
              lst.res[3] = '{ACT_SEND, hdr_new[7:0]};
              lst.cnt    = 3'd4;
            end
          end
        end else if (!fifo_mode) begin
          lst.res[0] = '{ACT_SEND, data_byte};
          lst.cnt    = 3'd1;
        end else if (credit_left == '0) begin
          // Out of credit: park the byte and poll for space.
          pending_byte_next   = data_byte;
          pending_valid_next  = 1'b1;
          awaiting_space_next = 1'b1;
          wait_count_next     = '0;
          cs_asserted_next    = 1'b0;
          if (cs_asserted) begin
            lst.res[0] = '{ACT_RELEASE, 8'd0};
            lst.res[1] = '{ACT_READ, 8'd0};
            lst.cnt    = 3'd2;
          end else begin
            lst.res[0] = '{ACT_READ, 8'd0};
            lst.cnt    = 3'd1;
          end
        end else begin
          credit_left_next = credit_left - 1'b1;
          burst_phase_next = burst_phase + 2'd1;
          lst.res[0] = '{ACT_SEND, data_byte};
          lst.cnt    = 3'd1;
        end
      end
      CMD_DESELECT: begin
        if (!(is_selected && header_count == 2'd3 && (!fifo_mode || burst_phase == 2'd0)))
          lst.status = ST_CONTEXT;
        if (cs_asserted) begin
          lst.res[0] = '{ACT_RELEASE, 8'd0};
          lst.cnt    = 3'd1;
        end
        is_selected_next    = 1'b0;
        cs_asserted_next    = 1'b0;
        awaiting_space_next = 1'b0;
        pending_valid_next  = 1'b0;
      end
      CMD_SPACE: begin
        if (!awaiting_space) begin
          lst.status = ST_CONTEXT;
        end else if (!bus_ok) begin
          lst.status          = ST_BUS;
          awaiting_space_next = 1'b0;
          pending_valid_next  = 1'b0;
          credit_left_next    = '0;
        end else if (space_value[1:0] != 2'd0 ||
                     space_value > {{(SPACE_W-CAP_W){1'b0}}, cfg.fifo_capacity}) begin
          lst.status          = ST_SPACE_FAULT;
          awaiting_space_next = 1'b0;
          pending_valid_next  = 1'b0;
          credit_left_next    = '0;
        end else if (space_value != '0) begin
          // Good reply: reopen the burst and replay the header.
          awaiting_space_next = 1'b0;
          cs_asserted_next    = 1'b1;
          credit_left_next    = space_value[CAP_W-1:0];
          lst.res[0] = '{ACT_ASSERT, 8'd0};
          lst.res[1] = '{ACT_SEND, header_bytes[23:16]};
          lst.res[2] = '{ACT_SEND, header_bytes[15:8]};
          lst.res[3] = '{ACT_SEND, header_bytes[7:0]};
          lst.cnt    = 3'd4;
          if (pending_valid) begin
            pending_valid_next = 1'b0;
            credit_left_next   = space_value[CAP_W-1:0] - 1'b1;
            burst_phase_next   = burst_phase + 2'd1;
            lst.res[4] = '{ACT_SEND, pending_byte};
            lst.cnt    = 3'd5;
          end
        end
      end
      CMD_TICK: begin
        if (awaiting_space) begin
          wait_count_next = wait_inc;
          if (wait_inc >= cfg.timeout_ticks) begin
            lst.status          = ST_TIMEOUT;
            awaiting_space_next = 1'b0;
            pending_valid_next  = 1'b0;
            credit_left_next    = '0;
          end else begin
            lst.res[0] = '{ACT_READ, 8'd0};
            lst.cnt    = 3'd1;
          end
        end
      end
      CMD_RECEIVE: begin
        if (!is_selected || !cs_asserted || fifo_mode) begin
          lst.status = ST_CONTEXT;
        end else begin
          lst.res[0] = '{ACT_RECEIVE, 8'd0};
          lst.cnt    = 3'd1;
        end
      end
      default: ;
    endcase

    if (lst.cnt == '0) begin
      lst.res[0] = '{ACT_NONE, 8'd0};
      lst.cnt    = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_selected    <= 1'b0;
      header_count   <= 2'd0;
      header_bytes   <= '0;
      fifo_mode      <= 1'b0;
      cs_asserted    <= 1'b0;
      credit_left    <= '0;
      burst_phase    <= 2'd0;
      awaiting_space <= 1'b0;
      wait_count     <= '0;
      pending_byte   <= '0;
      pending_valid  <= 1'b0;
    end else if (accept) begin
      is_selected    <= is_selected_next;
      header_count   <= header_count_next;
      header_bytes   <= header_bytes_next;
      fifo_mode      <= fifo_mode_next;
      cs_asserted    <= cs_asserted_next;
      credit_left    <= credit_left_next;
      burst_phase    <= burst_phase_next;
      awaiting_space <= awaiting_space_next;
      wait_count     <= wait_count_next;
      pending_byte   <= pending_byte_next;
      pending_valid  <= pending_valid_next;
    end
  end

endmodule

@@ hw/rtl/sfcg_out.sv @@
module sfcg_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  sfcg_pkg::res_list_t         lst,
  input  logic [sfcg_pkg::ADDR_W-1:0] space_address,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  action,
  output logic [7:0]                  out_byte,
  output logic [sfcg_pkg::ADDR_W-1:0] read_address,
  output logic [2:0]                  status,
  output logic                        last
);
  import sfcg_pkg::*;

  res_t [MAX_RES-1:0] pend;
  status_t            pend_status;
  logic [CNT_W-1:0]   rem_cnt;
  logic               out_free;
  res_t               head;

  assign out_free = !out_valid || !out_stall;
  assign busy     = (rem_cnt != '0);
  assign head     = (accept && rem_cnt == '0) ? lst.res[0] : pend[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem_cnt   <= '0;
    end else begin
      if (accept) begin
        pend_status <= lst.status;
        if (out_free) begin
          // First word goes straight to the output register.
          out_valid <= 1'b1;
          status    <= lst.status;
          last      <= (lst.cnt == 3'd1);
          for (int i = 0; i < MAX_RES - 1; i++) pend[i] <= lst.res[i+1];
          rem_cnt   <= lst.cnt - 3'd1;
        end else begin
          pend    <= lst.res;
          rem_cnt <= lst.cnt;
        end
      end else if (out_free && rem_cnt != '0) begin
        out_valid <= 1'b1;
        status    <= pend_status;
        last      <= (rem_cnt == 3'd1);
        for (int i = 0; i < MAX_RES - 1; i++) pend[i] <= pend[i+1];
        rem_cnt   <= rem_cnt - 3'd1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the output register, loaded whenever a word moves in.
  always_ff @(posedge clk) begin
    if (out_free && (accept || rem_cnt != '0)) begin
      action       <= head.action;
      out_byte     <= (head.action == ACT_SEND) ? head.data : 8'd0;
      read_address <= (head.action == ACT_READ) ? space_address : '0;
    end
  end

endmodule

@@ dv/credit_gate_check_pkg.sv @@
package credit_gate_check_pkg;
  import sfcg_pkg::*;

  typedef struct {
    action_t           act;
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    status_t           st;
    logic              fin;
  } bus_word_t;

  class credit_gate_model;
    logic [ADDR_W-1:0] fifo_addr  = RST_FIFO_ADDR;
    logic [ADDR_W-1:0] space_addr = RST_SPACE_ADDR;
    logic [CAP_W-1:0]  cap        = RST_CAPACITY;
    logic [TICK_W-1:0] timeout    = RST_TIMEOUT;

    logic              selected   = 1'b0;
    logic [1:0]        hdr_cnt    = '0;
    logic [23:0]       hdr        = '0;
    logic              fifo_mode  = 1'b0;
    logic              cs_on      = 1'b0;
    logic [CAP_W-1:0]  credit     = '0;
    logic [1:0]        phase      = '0;
    logic              waiting    = 1'b0;
    logic [TICK_W-1:0] wait_cnt   = '0;
    logic [7:0]        pend_byte  = '0;
    logic              pend_valid = 1'b0;

    bus_word_t expected_words[$];
    bus_word_t step_words[$];
    int        mismatches = 0;

    function void set_reg(reg_idx_t idx, logic [ADDR_W-1:0] value);
      case (idx)
        REG_FIFO_ADDR:  fifo_addr  = value;
        REG_SPACE_ADDR: space_addr = value;
        REG_CAPACITY:   cap        = value[CAP_W-1:0];
        REG_TIMEOUT:    timeout    = value[TICK_W-1:0];
        default:        ;
      endcase
    endfunction

    function void push_action(action_t a, logic [7:0] d = 8'h00,
                              logic [ADDR_W-1:0] ad = '0);
      bus_word_t w;
      w.act  = a;
      w.data = d;
      w.addr = ad;
      w.st   = ST_OK;
      w.fin  = 1'b0;
      step_words.push_back(w);
    endfunction

    function void replay_header();
      push_action(ACT_ASSERT);
      cs_on = 1'b1;
      push_action(ACT_SEND, hdr[23:16]);
      push_action(ACT_SEND, hdr[15:8]);
      push_action(ACT_SEND, hdr[7:0]);
    endfunction

    function void poll_space();
      if (cs_on) begin
        push_action(ACT_RELEASE);
        cs_on = 1'b0;
      end
      push_action(ACT_READ, 8'h00, space_addr);
      waiting  = 1'b1;
      wait_cnt = '0;
    endfunction

    function void drop_wait();
      waiting    = 1'b0;
      pend_valid = 1'b0;
      credit     = '0;
    endfunction

    function void send_credit(logic [7:0] b);
      push_action(ACT_SEND, b);
      credit = credit - 1'b1;
      phase  = phase + 1'b1;
    endfunction

    // Work out the result words of one accepted input word.
    function void note_item(logic [2:0] c, logic [7:0] db, logic [SPACE_W-1:0] sv,
                            logic ok);
      status_t st;
      logic    clean_close;
      st = ST_OK;
      step_words.delete();
      case (c)
        CMD_SELECT: begin
          if (selected) begin
            st = ST_CONTEXT;
          end else begin
            selected   = 1'b1;
            hdr_cnt    = '0;
            fifo_mode  = 1'b0;
            cs_on      = 1'b0;
            waiting    = 1'b0;
            pend_valid = 1'b0;
            credit     = '0;
            phase      = '0;
            wait_cnt   = '0;
          end
        end
        CMD_DATA: begin
          if (!selected || waiting) begin
            st = ST_CONTEXT;
          end else if (hdr_cnt != 2'd3) begin
            hdr     = {hdr[15:0], db};
            hdr_cnt = hdr_cnt + 1'b1;
            if (hdr_cnt == 2'd3) begin
              fifo_mode = hdr[23] && (hdr[ADDR_W-1:0] == fifo_addr);
              if (fifo_mode) poll_space();
              else replay_header();
            end
          end else if (!fifo_mode) begin
            push_action(ACT_SEND, db);
          end else if (credit == '0) begin
            pend_byte  = db;
            pend_valid = 1'b1;
            poll_space();
          end else begin
            send_credit(db);
          end
        end
        CMD_DESELECT: begin
          clean_close = selected && hdr_cnt == 2'd3 && (!fifo_mode || phase == 2'd0);
          st = clean_close ? ST_OK : ST_CONTEXT;
          if (cs_on) push_action(ACT_RELEASE);
          selected   = 1'b0;
          cs_on      = 1'b0;
          waiting    = 1'b0;
          pend_valid = 1'b0;
        end
        CMD_SPACE: begin
          if (!waiting) begin
            st = ST_CONTEXT;
          end else if (!ok) begin
            st = ST_BUS;
            drop_wait();
          end else if (sv[1:0] != 2'b00 || sv > {4'b0, cap}) begin
            st = ST_SPACE_FAULT;
            drop_wait();
          end else if (sv >= 16'd4) begin
            waiting = 1'b0;
            credit  = sv[CAP_W-1:0];
            replay_header();
            if (pend_valid) begin
              pend_valid = 1'b0;
              send_credit(pend_byte);
            end
          end
        end
        CMD_TICK: begin
          if (waiting) begin
            if (wait_cnt != '1) wait_cnt = wait_cnt + 1'b1;
            if (wait_cnt >= timeout) begin
              st = ST_TIMEOUT;
              drop_wait();
            end else begin
              push_action(ACT_READ, 8'h00, space_addr);
            end
          end
        end
        CMD_RECEIVE: begin
          if (!selected || !cs_on || fifo_mode) st = ST_CONTEXT;
          else push_action(ACT_RECEIVE);
        end
        default: ;
      endcase
      if (step_words.size() == 0) push_action(ACT_NONE);
      foreach (step_words[i]) step_words[i].st = st;
      step_words[step_words.size() - 1].fin = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_word(logic [2:0] a, logic [7:0] d, logic [ADDR_W-1:0] ad,
                             logic [2:0] s, logic l);
      bus_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word action=%0d byte=%02h addr=%06h status=%0d last=%0b",
                   $time, a, d, ad, s, l);
        return;
      end
      w = expected_words.pop_front();
      if (w.act !== a || w.data !== d || w.addr !== ad || w.st !== s || w.fin !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result word differs: expected action=%0d byte=%02h addr=%06h",
                    " status=%0d last=%0b, got action=%0d byte=%02h addr=%06h",
                    " status=%0d last=%0b"},
                   $time, w.act, w.data, w.addr, w.st, w.fin, a, d, ad, s, l);
      end
    endfunction
  endclass

endpackage

@@ dv/spi_fifo_credit_gate_tb.sv @@
module spi_fifo_credit_gate_tb;
  import sfcg_pkg::*;
  import credit_gate_check_pkg::*;

  // Command codes the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [ADDR_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         cmd;
  logic [7:0]         data_byte;
  logic [SPACE_W-1:0] space_value;
  logic               bus_ok;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         action;
  logic [7:0]         out_byte;
  logic [ADDR_W-1:0]  read_address;
  logic [2:0]         status;
  logic               last;

  credit_gate_model gate = new();

  int words_sent   = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;

  spi_fifo_credit_gate u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Per-word pause for either side; zero for the whole transaction when a
  // back-to-back stretch is in effect.
  function automatic int pause_len();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Hold the word until the block takes it, then log it with the predictor.
  // Leave valid high so the next word can follow without a bubble.
  task automatic send_word(logic [2:0] c, logic [7:0] db, logic [SPACE_W-1:0] sv,
                           logic ok);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    data_byte   <= db;
    space_value <= sv;
    bus_ok      <= ok;
    do @(posedge clk); while (in_stall);
    gate.note_item(c, db, sv, ok);
    words_sent++;
  endtask

  // Same, with the byte, space and bus-ok fields filled with noise.
  task automatic send_op(logic [2:0] c);
    send_word(c, $urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  task automatic send_header_bytes(logic [23:0] h, int n);
    for (int i = 0; i < n; i++)
      send_word(CMD_DATA, h[23 - 8*i -: 8], $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  // Drop valid and wait for every outstanding result word to come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (gate.expected_words.size() != 0);
  endtask

  // Keep cfg_valid high across back-to-back writes; drop it once after the last.
  task automatic write_reg(reg_idx_t idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    gate.set_reg(idx, value);
  endtask

  task automatic load_config(logic [ADDR_W-1:0] fa, logic [ADDR_W-1:0] sa,
                             logic [CAP_W-1:0] cp, logic [TICK_W-1:0] to);
    write_reg(REG_FIFO_ADDR, fa);
    write_reg(REG_SPACE_ADDR, sa);
    write_reg(REG_CAPACITY, {{(ADDR_W-CAP_W){1'b0}}, cp});
    write_reg(REG_TIMEOUT, {{(ADDR_W-TICK_W){1'b0}}, to});
    cfg_valid <= 1'b0;
  endtask

  // Answer an outstanding space read: mostly small legal replies so credit
  // runs out again soon, mixed with ticks, zero replies, faults and bus errors.
  task automatic serve_poll();
    int               tries;
    int               roll;
    int               quarter;
    logic [SPACE_W-1:0] sv;
    tries = 0;
    while (gate.waiting && tries < 4) begin
      tries++;
      repeat ($urandom_range(0, 2)) begin
        if (gate.waiting) send_op(CMD_TICK);
      end
      // a byte sent while waiting gets dropped
      if ($urandom_range(0, 9) == 0) send_op(CMD_DATA);
      quarter = gate.cap / 4;
      roll    = $urandom_range(0, 99);
      if (roll < 55)      sv = 4 * $urandom_range(1, quarter < 4 ? quarter : 4);
      else if (roll < 70) sv = 4 * $urandom_range(1, quarter);
      else if (roll < 76) sv = '0;
      else if (roll < 84) sv = (4 * $urandom_range(0, quarter)) | $urandom_range(1, 3);
      else if (roll < 92) sv = $urandom_range(gate.cap + 1, 65535);
      else                sv = $urandom_range(0, 65535);
      send_word(CMD_SPACE, $urandom_range(0, 255), sv, $urandom_range(0, 11) != 0);
    end
  endtask

  // Credit burst: select, FIFO write header, payload, deselect, with stray commands now and then.
  task automatic fifo_burst();
    int          nbytes;
    logic [23:0] h;
    if (gate.selected) send_op(CMD_DESELECT);
    send_op(CMD_SELECT);
    h     = {1'b1, 1'b0, gate.fifo_addr};
    h[22] = $urandom_range(0, 1);  // outside the address, must not matter
    send_header_bytes(h, 3);
    serve_poll();
    nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 4 * $urandom_range(1, 3);
    repeat (nbytes) begin
      if ($urandom_range(0, 15) == 0)
        send_op($urandom_range(0, 1) ? CMD_RECEIVE : CMD_SELECT);
      send_op(CMD_DATA);
      if (gate.waiting) serve_poll();
    end
    send_op(CMD_DESELECT);
  endtask

  // Pass-through transfer, sometimes with a short header.
  task automatic plain_transfer();
    logic [23:0] h;
    int          hlen;
    h = $urandom_range(0, 24'hFFFFFF);
    if ($urandom_range(0, 1)) h[23] = 1'b0;
    hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
    send_op(CMD_SELECT);
    send_header_bytes(h, hlen);
    repeat ($urandom_range(0, 5))
      send_op($urandom_range(0, 3) == 0 ? CMD_RECEIVE : CMD_DATA);
    send_op(CMD_DESELECT);
  endtask

  task automatic random_phase(int n);
    int goal;
    int pick;
    goal = words_sent + n;
    while (words_sent < goal) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 6)      fifo_burst();
      else if (pick < 8) plain_transfer();
      else begin
        repeat ($urandom_range(1, 4)) send_op($urandom_range(0, 7));
      end
    end
    no_idle = 1'b0;
  endtask

  // Walk every command and each corner of the credit handshake but the timeout once
  // under the reset register values.
  task automatic run_directed();
    send_op(CMD_TICK);                                 // tick with nothing pending
    send_op(CMD_SPARE_6);
    send_op(CMD_SPARE_7);
    send_word(CMD_SPACE, 8'h00, 16'hFFFF, 1'b1);       // reply nobody asked for
    send_op(CMD_DATA);                                 // everything below needs select
    send_op(CMD_RECEIVE);
    send_op(CMD_DESELECT);
    send_op(CMD_SELECT);
    send_op(CMD_SELECT);                               // second select is refused
    send_header_bytes(24'h000000, 3);                  // read header, replayed
    send_op(CMD_RECEIVE);
    send_op(CMD_DESELECT);
    send_op(CMD_SELECT);
    send_header_bytes({1'b1, 1'b1, RST_FIFO_ADDR}, 3); // FIFO write opens a space poll
    send_op(CMD_DATA);                                 // dropped while polling
    send_op(CMD_TICK);                                 // poll again
    send_word(CMD_SPACE, 8'h00, 16'd0, 1'b1);          // no space yet, keep waiting
    send_word(CMD_SPACE, 8'h00, 16'd8, 1'b0);          // bus error ends the wait
    send_word(CMD_DATA, 8'hFF, 16'h0000, 1'b0);        // zero credit, byte held
    send_word(CMD_SPACE, 8'h00, 16'd6, 1'b1);          // misaligned reply
    send_op(CMD_DATA);
    send_word(CMD_SPACE, 8'h00, {4'b0, RST_CAPACITY} + 16'd4, 1'b1); // over capacity
    send_op(CMD_DATA);
    send_word(CMD_SPACE, 8'h00, {4'b0, RST_CAPACITY}, 1'b1); // header replay plus byte
    send_op(CMD_RECEIVE);                              // refused in credit mode
    send_op(CMD_DATA);
    send_op(CMD_DESELECT);                             // burst not word aligned
  endtask

  // Result side: stall a random number of cycles before each word.
  initial begin : result_sink
    int hold;
    forever begin
      hold = pause_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every result word taken at this edge against the predictor.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      gate.check_word(action, out_byte, read_address, status, last);
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= CMD_SELECT;
    data_byte   <= 8'h00;
    space_value <= '0;
    bus_ok      <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_FIFO_ADDR;
    cfg_data    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Lowest FIFO address, highest poll address, tightest capacity, instant timeout.
    hold_until_drained();
    load_config('0, '1, 12'd4, 16'd1);
    random_phase(30);
    // Let the block empty out completely mid-run.
    hold_until_drained();
    random_phase(25);

    // Opposite extremes: a timeout that never fires in practice.
    hold_until_drained();
    load_config('1, '0, RST_CAPACITY, 16'hFFFF);
    random_phase(50);

    // Random addresses and capacity, short timeout.
    hold_until_drained();
    load_config($urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
                $urandom_range(4, 4092), $urandom_range(2, 6));
    random_phase(50);

    // Back to the power-up map with a few ticks of patience.
    hold_until_drained();
    load_config(RST_FIFO_ADDR, RST_SPACE_ADDR, RST_CAPACITY, 16'd3);
    random_phase(50);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (gate.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
